// File: rtl/counting_semaphore_bank_unit_assert.svh
// Assertion macros for the semaphore bank
`ifndef COUNTING_SEMAPHORE_BANK_UNIT_ASSERT_SVH
`define COUNTING_SEMAPHORE_BANK_UNIT_ASSERT_SVH

// same-cycle implication
`define CSB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CSB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/csb_pkg.sv
// Shared widths, codes and types of the semaphore bank
package csb_pkg;

	localparam int ACTION_W = 2;
	localparam int INDEX_W  = 8;
	localparam int INIT_W   = 15;
	localparam int TASK_W   = 4;
	localparam int COUNT_W  = 16;

	localparam logic [ACTION_W-1:0] ACT_INIT   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_WAIT   = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_SIGNAL = 2'd2;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_IDX = 1'b1;

	localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7FFF;
	localparam logic signed [COUNT_W-1:0] COUNT_MIN = 16'sh8000;

	typedef struct packed {
		logic                        nonempty;
		logic [TASK_W-1:0]           head;
		logic [TASK_W-1:0]           tail;
		logic signed [COUNT_W-1:0]   count;
	} sem_entry_t;

endpackage

// File: rtl/csb_req_if.sv
// Request channel of the semaphore bank
interface csb_req_if;
	logic                           valid;
	logic                           ready;
	logic [csb_pkg::ACTION_W-1:0]   action;
	logic [csb_pkg::INDEX_W-1:0]    sem_index;
	logic [csb_pkg::INIT_W-1:0]     init_value;
	logic [csb_pkg::TASK_W-1:0]     task_id;

	modport source (output valid, action, sem_index, init_value, task_id, input ready);
	modport sink (input valid, action, sem_index, init_value, task_id, output ready);
endinterface

// File: rtl/csb_rsp_if.sv
// Result channel of the semaphore bank
interface csb_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        status;
	logic                        caller_blocked;
	logic                        woken_valid;
	logic [csb_pkg::TASK_W-1:0]  woken_task;

	modport source (output valid, status, caller_blocked, woken_valid, woken_task, input ready);
	modport sink (input valid, status, caller_blocked, woken_valid, woken_task, output ready);
endinterface

// File: rtl/csb_ram.sv
// Generic single-port-write, registered-read RAM
module csb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// File: rtl/counting_semaphore_bank_unit.sv
// Counting semaphore bank with per-semaphore FIFO wait queues
// A request is taken only in IDLE; in RD its semaphore entry is
// modified and written back, and a signal that releases a waiter while
// others stay queued goes on to NW to use the task link memory read
// at the old head. Counts and queue flags reset at once through one
// valid bit per semaphore, so there is no clearing pass. A finished
// word waits in the output register while the next request is taken.
`include "counting_semaphore_bank_unit_assert.svh"

module counting_semaphore_bank_unit #(
	parameter int NUM_SEMAPHORES = 32,
	parameter int NUM_TASKS      = 16
) (
	input logic       clk,
	input logic       arst_n,
	csb_req_if.sink   req,
	csb_rsp_if.source rsp
);
	localparam int SW = NUM_SEMAPHORES > 1 ? $clog2(NUM_SEMAPHORES) : 1;
	localparam int TW = NUM_TASKS > 1 ? $clog2(NUM_TASKS) : 1;
	localparam int ENTRY_W = $bits(csb_pkg::sem_entry_t);

	typedef enum logic [1:0] {ST_IDLE, ST_RD, ST_NW} state_t;

	function automatic logic [csb_pkg::TASK_W-1:0] task_mod(
		input logic [csb_pkg::TASK_W-1:0] t);
		logic [csb_pkg::TASK_W:0] v;
		v = {1'b0, t};
		for (int i = 0; i < 8; i++) begin
			if (int'(v) >= NUM_TASKS) begin
				v = v - (csb_pkg::TASK_W+1)'(NUM_TASKS);
			end
		end
		return v[csb_pkg::TASK_W-1:0];
	endfunction

	state_t                          state_q;
	logic [csb_pkg::ACTION_W-1:0]    action_s1;
	logic [SW-1:0]                   idx_s1;
	logic                            idx_ok_s1;
	logic [csb_pkg::INIT_W-1:0]      init_s1;
	logic [csb_pkg::TASK_W-1:0]      task_s1;
	logic [NUM_SEMAPHORES-1:0]       valid_q;

	logic                            out_valid_q;
	logic                            status_q;
	logic                            blocked_q;
	logic                            wvalid_q;
	logic [csb_pkg::TASK_W-1:0]      wtask_q;

	logic                            accept;
	logic                            out_free;
	logic [ENTRY_W-1:0]              sem_rdata;
	csb_pkg::sem_entry_t             ent_rd;
	csb_pkg::sem_entry_t             ent_wr;
	logic                            sem_we;
	logic [csb_pkg::TASK_W-1:0]      nw_rdata;
	logic                            nw_re;
	logic                            nw_we;
	logic [TW-1:0]                   nw_waddr;
	logic [csb_pkg::TASK_W-1:0]      nw_wdata;

	logic signed [csb_pkg::COUNT_W-1:0] cnt;
	logic signed [csb_pkg::COUNT_W-1:0] newc;
	logic                            ne;
	logic                            wake;
	logic                            commit;
	logic                            go_nw;
	logic                            res_status;
	logic                            res_blocked;
	logic                            res_wvalid;
	logic [csb_pkg::TASK_W-1:0]      res_wtask;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || rsp.ready;

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = status_q;
	assign rsp.caller_blocked = blocked_q;
	assign rsp.woken_valid    = wvalid_q;
	assign rsp.woken_task     = wtask_q;

	csb_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_SEMAPHORES)) u_sem_ram (
		.clk   (clk),
		.we    (sem_we),
		.waddr (idx_s1),
		.wdata (ENTRY_W'(ent_wr)),
		.re    (accept),
		.raddr (req.sem_index[SW-1:0]),
		.rdata (sem_rdata)
	);

	csb_ram #(.WIDTH(csb_pkg::TASK_W), .DEPTH(NUM_TASKS)) u_link_ram (
		.clk   (clk),
		.we    (nw_we),
		.waddr (nw_waddr),
		.wdata (nw_wdata),
		.re    (nw_re),
		.raddr (TW'(ent_rd.head)),
		.rdata (nw_rdata)
	);

	always_comb begin
		ent_rd      = csb_pkg::sem_entry_t'(sem_rdata);
		cnt         = valid_q[idx_s1] ? ent_rd.count : '0;
		ne          = valid_q[idx_s1] && ent_rd.nonempty;
		ent_wr      = ent_rd;
		ent_wr.count    = cnt;
		ent_wr.nonempty = ne;
		newc        = cnt;
		wake        = 1'b0;
		commit      = 1'b0;
		go_nw       = 1'b0;
		sem_we      = 1'b0;
		nw_re       = 1'b0;
		nw_we       = 1'b0;
		nw_waddr    = TW'(ent_rd.tail);
		nw_wdata    = task_s1;
		res_status  = csb_pkg::STATUS_OK;
		res_blocked = 1'b0;
		res_wvalid  = 1'b0;
		res_wtask   = '0;

		case (action_s1)
			csb_pkg::ACT_WAIT: begin
				newc = (cnt != csb_pkg::COUNT_MIN) ? cnt - 16'sd1 : cnt;
			end
			csb_pkg::ACT_SIGNAL: begin
				newc = (cnt != csb_pkg::COUNT_MAX) ? cnt + 16'sd1 : cnt;
			end
			default: begin
				newc = cnt;
			end
		endcase
		wake = (newc[csb_pkg::COUNT_W-1] || newc == '0) && ne;

		case (state_q)
			ST_RD: begin
				if (!idx_ok_s1) begin
					commit     = out_free;
					res_status = csb_pkg::STATUS_IDX;
				end else begin
					case (action_s1)
						csb_pkg::ACT_INIT: begin
							commit          = out_free;
							sem_we          = out_free;
							ent_wr.count    = {1'b0, init_s1};
							ent_wr.nonempty = 1'b0;
						end
						csb_pkg::ACT_WAIT: begin
							commit       = out_free;
							sem_we       = out_free;
							ent_wr.count = newc;
							if (newc[csb_pkg::COUNT_W-1]) begin
								res_blocked = 1'b1;
								ent_wr.tail = task_s1;
								if (ne) begin
									nw_we = out_free;
								end else begin
									ent_wr.head     = task_s1;
									ent_wr.nonempty = 1'b1;
								end
							end
						end
						csb_pkg::ACT_SIGNAL: begin
							ent_wr.count = newc;
							if (wake && ent_rd.head != ent_rd.tail) begin
								go_nw = 1'b1;
								nw_re = 1'b1;
							end else begin
								commit = out_free;
								sem_we = out_free;
								if (wake) begin
									res_wvalid      = 1'b1;
									res_wtask       = ent_rd.head;
									ent_wr.nonempty = 1'b0;
								end
							end
						end
						default: begin
							commit = out_free;
						end
					endcase
				end
			end
			ST_NW: begin
				commit       = out_free;
				sem_we       = out_free;
				ent_wr.count = newc;
				ent_wr.head  = nw_rdata;
				res_wvalid   = 1'b1;
				res_wtask    = ent_rd.head;
			end
			default: begin
				commit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
			action_s1   <= csb_pkg::ACT_INIT;
			idx_s1      <= '0;
			idx_ok_s1   <= 1'b0;
			init_s1     <= '0;
			task_s1     <= '0;
			status_q    <= 1'b0;
			blocked_q   <= 1'b0;
			wvalid_q    <= 1'b0;
			wtask_q     <= '0;
		end else begin
			if (accept) begin
				action_s1 <= req.action;
				idx_s1    <= req.sem_index[SW-1:0];
				idx_ok_s1 <= ({1'b0, req.sem_index} < (csb_pkg::INDEX_W+1)'(NUM_SEMAPHORES));
				init_s1   <= req.init_value;
				task_s1   <= task_mod(req.task_id);
			end
			if (sem_we) begin
				valid_q[idx_s1] <= 1'b1;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
				status_q    <= res_status;
				blocked_q   <= res_blocked;
				wvalid_q    <= res_wvalid;
				wtask_q     <= res_wtask;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					if (go_nw) begin
						state_q <= ST_NW;
					end else if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				ST_NW: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`CSB_ASSERT_NEXT(a_accept_busy, accept, !req.ready, "request taken while busy")
	`CSB_ASSERT_NOW(a_err_no_write, commit && !idx_ok_s1, !sem_we && !nw_we,
		"state written on rejected index")
	`CSB_ASSERT_NOW(a_nw_signal, state_q == ST_NW, action_s1 == csb_pkg::ACT_SIGNAL,
		"link read outside a signal")
	`CSB_ASSERT_NEXT(a_write_word, sem_we, out_valid_q, "write back without a result word")
	`CSB_ASSERT_NOW(a_excl_fields, rsp.valid, !(rsp.woken_valid && rsp.caller_blocked),
		"word both blocks and wakes")

endmodule

// File: bench/counting_semaphore_bank_unit_tb.sv
// Self-checking bench for the counting semaphore bank: queued requests, predicted results
`timescale 1ns / 1ps

module counting_semaphore_bank_unit_tb;

	localparam int NUM_SEM = 32;
	localparam int NUM_TSK = 16;
	localparam logic [csb_pkg::ACTION_W-1:0] ACT_NONE = 2'd3;
	localparam int DEEP_WAITS = 24;
	localparam int PHASE_WORDS = 160;
	localparam int MAX_REPORTS = 40;
	localparam int SETTLE_CYCLES = 20;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct {
		logic [csb_pkg::ACTION_W-1:0] action;
		logic [csb_pkg::INDEX_W-1:0]  sem_index;
		logic [csb_pkg::INIT_W-1:0]   init_value;
		logic [csb_pkg::TASK_W-1:0]   task_id;
		int unsigned                  gap_pct;
		int unsigned                  stall_pct;
		bit                           drain_first;
	} req_word_t;

	typedef struct packed {
		logic                       status;
		logic                       caller_blocked;
		logic                       woken_valid;
		logic [csb_pkg::TASK_W-1:0] woken_task;
	} rsp_word_t;

	logic clk = 1'b0;
	logic arst_n;

	csb_req_if req();
	csb_rsp_if rsp();

	counting_semaphore_bank_unit #(
		.NUM_SEMAPHORES(NUM_SEM),
		.NUM_TASKS(NUM_TSK)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predicted bank state
	logic signed [csb_pkg::COUNT_W-1:0] count_of [NUM_SEM];
	logic [csb_pkg::TASK_W-1:0]         head_of  [NUM_SEM];
	logic [csb_pkg::TASK_W-1:0]         tail_of  [NUM_SEM];
	logic                               queued_of[NUM_SEM];
	logic [csb_pkg::TASK_W-1:0]         link_of  [NUM_TSK];

	req_word_t   pending_words[$];
	rsp_word_t   expected_outcomes[$];
	req_word_t   on_wire;
	int unsigned phase_gap;
	int unsigned phase_stall;
	bit          hold_next;
	int unsigned rx_stall_pct;
	int          words_sent;
	int          results_seen;
	int          blocks_seen;
	int          wakes_seen;
	int          mismatches;
	int          cycles;

	int unsigned gap_by_phase[4]   = '{0, 54, 0, 26};
	int unsigned stall_by_phase[4] = '{0, 0, 54, 26};

	function automatic rsp_word_t apply_request(req_word_t w);
		rsp_word_t r;
		int        i;
		logic [csb_pkg::TASK_W-1:0] h;
		r = '0;
		i = w.sem_index;
		if (w.sem_index >= NUM_SEM) begin
			r.status = csb_pkg::STATUS_IDX;
		end else begin
			r.status = csb_pkg::STATUS_OK;
			case (w.action)
				csb_pkg::ACT_INIT: begin
					count_of[i]  = {1'b0, w.init_value};
					queued_of[i] = 1'b0;
				end
				csb_pkg::ACT_WAIT: begin
					if (count_of[i] != csb_pkg::COUNT_MIN)
						count_of[i] = count_of[i] - 16'sd1;
					if (count_of[i] < 0) begin
						if (queued_of[i])
							link_of[tail_of[i]] = w.task_id;
						else begin
							head_of[i]   = w.task_id;
							queued_of[i] = 1'b1;
						end
						tail_of[i]       = w.task_id;
						r.caller_blocked = 1'b1;
					end
				end
				csb_pkg::ACT_SIGNAL: begin
					if (count_of[i] != csb_pkg::COUNT_MAX)
						count_of[i] = count_of[i] + 16'sd1;
					if (count_of[i] <= 0 && queued_of[i]) begin
						h             = head_of[i];
						r.woken_valid = 1'b1;
						r.woken_task  = h;
						if (h == tail_of[i])
							queued_of[i] = 1'b0;
						else
							head_of[i] = link_of[h];
					end
				end
				default: ;
			endcase
		end
		return r;
	endfunction

	function automatic void push_word(logic [csb_pkg::ACTION_W-1:0] a, int unsigned idx,
		int unsigned v, int unsigned tid);
		req_word_t w;
		w.action      = a;
		w.sem_index   = idx[csb_pkg::INDEX_W-1:0];
		w.init_value  = v[csb_pkg::INIT_W-1:0];
		w.task_id     = tid[csb_pkg::TASK_W-1:0];
		w.gap_pct     = phase_gap;
		w.stall_pct   = phase_stall;
		w.drain_first = hold_next;
		hold_next     = 1'b0;
		pending_words.push_back(w);
	endfunction

	// mostly a few hot semaphores so wait queues grow and drain
	function automatic void push_random_word();
		int unsigned pick;
		logic [csb_pkg::ACTION_W-1:0] a;
		int unsigned idx;
		int unsigned v;
		pick = $urandom_range(99);
		if (pick < 40)
			a = csb_pkg::ACT_WAIT;
		else if (pick < 80)
			a = csb_pkg::ACT_SIGNAL;
		else if (pick < 92)
			a = csb_pkg::ACT_INIT;
		else
			a = ACT_NONE;
		pick = $urandom_range(99);
		if (pick < 80)
			idx = $urandom_range(3);
		else if (pick < 94)
			idx = $urandom_range(NUM_SEM - 1);
		else
			idx = $urandom_range(255);
		pick = $urandom_range(99);
		if (pick < 70)
			v = $urandom_range(3);
		else if (pick < 90)
			v = $urandom;
		else
			v = 32767;
		push_word(a, idx, v, $urandom_range(NUM_TSK - 1));
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatches < MAX_REPORTS)
			$display("MISMATCH at %0t: %s", $time, msg);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin : driver
		logic fire;
		logic drained;
		if (!arst_n) begin
			req.valid      <= 1'b0;
			req.action     <= csb_pkg::ACT_INIT;
			req.sem_index  <= '0;
			req.init_value <= '0;
			req.task_id    <= '0;
		end else begin
			fire = 1'b0;
			if (req.valid && req.ready) begin
				expected_outcomes.push_back(apply_request(on_wire));
				words_sent++;
			end
			if (!req.valid || req.ready) begin
				drained = (expected_outcomes.size() == 0) && !(rsp.valid && rsp.ready);
				if (pending_words.size() != 0 && (!pending_words[0].drain_first || drained)
					&& $urandom_range(99) >= pending_words[0].gap_pct) begin
					on_wire = pending_words.pop_front();
					fire    = 1'b1;
					req.action     <= on_wire.action;
					req.sem_index  <= on_wire.sem_index;
					req.init_value <= on_wire.init_value;
					req.task_id    <= on_wire.task_id;
					rx_stall_pct   <= on_wire.stall_pct;
				end
				req.valid <= fire;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		rsp_word_t want;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				results_seen++;
				if (expected_outcomes.size() == 0) begin
					report_mismatch("result word with nothing expected");
				end else begin
					want = expected_outcomes.pop_front();
					blocks_seen += want.caller_blocked;
					wakes_seen  += want.woken_valid;
					if (rsp.status !== want.status)
						report_mismatch($sformatf("word %0d: status %b, expected %b",
							results_seen, rsp.status, want.status));
					if (rsp.caller_blocked !== want.caller_blocked)
						report_mismatch($sformatf("word %0d: caller_blocked %b, expected %b",
							results_seen, rsp.caller_blocked, want.caller_blocked));
					if (rsp.woken_valid !== want.woken_valid)
						report_mismatch($sformatf("word %0d: woken_valid %b, expected %b",
							results_seen, rsp.woken_valid, want.woken_valid));
					if (rsp.woken_task !== want.woken_task)
						report_mismatch($sformatf("word %0d: woken_task %0d, expected %0d",
							results_seen, rsp.woken_task, want.woken_task));
				end
			end
			rsp.ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still due",
				cycles, expected_outcomes.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		req.valid      = 1'b0;
		req.action     = csb_pkg::ACT_INIT;
		req.sem_index  = '0;
		req.init_value = '0;
		req.task_id    = '0;
		rsp.ready      = 1'b0;
		rx_stall_pct   = 0;
		phase_gap      = 0;
		phase_stall    = 0;
		hold_next      = 1'b0;
		for (int i = 0; i < NUM_SEM; i++) begin
			count_of[i]  = '0;
			head_of[i]   = '0;
			tail_of[i]   = '0;
			queued_of[i] = 1'b0;
		end
		for (int t = 0; t < NUM_TSK; t++)
			link_of[t] = '0;

		// fill a queue with every task so every link entry gets written,
		// task 5 twice to leave a repeat in the queue
		push_word(csb_pkg::ACT_INIT, NUM_SEM - 1, 0, 0);
		for (int t = 1; t < NUM_TSK; t++)
			push_word(csb_pkg::ACT_WAIT, NUM_SEM - 1, 0, t);
		push_word(csb_pkg::ACT_WAIT, NUM_SEM - 1, 0, 0);
		push_word(csb_pkg::ACT_WAIT, NUM_SEM - 1, 0, 5);
		push_word(csb_pkg::ACT_SIGNAL, NUM_SEM - 1, 0, 0);
		push_word(csb_pkg::ACT_SIGNAL, NUM_SEM - 1, 0, 0);
		push_word(csb_pkg::ACT_INIT, NUM_SEM - 1, 32767, 0);
		push_word(csb_pkg::ACT_SIGNAL, NUM_SEM - 1, 0, 0);
		push_word(csb_pkg::ACT_WAIT, NUM_SEM - 1, 0, 15);
		push_word(csb_pkg::ACT_WAIT, NUM_SEM, 0, 9);
		push_word(csb_pkg::ACT_SIGNAL, 255, 0, 0);
		push_word(ACT_NONE, 5, 32767, 15);
		push_word(csb_pkg::ACT_INIT, 128, 15'h2AAA, 10);

		// drive one count well below zero, then release one waiter
		hold_next = 1'b1;
		for (int n = 0; n < DEEP_WAITS; n++)
			push_word(csb_pkg::ACT_WAIT, 1, 0, $urandom_range(NUM_TSK - 1));
		push_word(csb_pkg::ACT_SIGNAL, 1, 0, 0);
		push_word(csb_pkg::ACT_INIT, 1, 0, 0);

		for (int p = 0; p < 4; p++) begin
			phase_gap   = gap_by_phase[p];
			phase_stall = stall_by_phase[p];
			hold_next   = 1'b1;
			repeat (PHASE_WORDS) push_random_word();
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_words.size() == 0 && !req.valid && expected_outcomes.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Run: %0d requests (directed, deep wait queue, four back-pressure phases)",
			words_sent);
		$display("Checked %0d results, %0d blocking waits, %0d wake-ups, %0d mismatches",
			results_seen, blocks_seen, wakes_seen, mismatches);
		if (mismatches == 0 && expected_outcomes.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
